// ===== sv/utf8dc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 display column counter - shared types and constants
// Per-word operation record passed from the decoder to the column unit,
// configuration and queue status bundles, and the wide-glyph range table.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

   // decoder to column unit queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // most single-column advances one word can cause
   localparam int MAX_ADV = 4;

   localparam logic [7:0]  TAB_WIDTH_RESET = 8'd8;
   localparam logic [7:0]  TAB_WIDTH_ZERO  = 8'd8;   // width used when 0 is written
   localparam logic [20:0] CP_TAB          = 21'h00009;

   // byte classes
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_TAG    = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_TAG    = 8'hE0;
   localparam logic [7:0] LEAD4_MASK   = 8'hF8;
   localparam logic [7:0] LEAD4_TAG    = 8'hF0;

   // register map (index = paddr[2])
   localparam logic REG_TAB_WIDTH = 1'b0;

   typedef struct packed {
      logic [2:0]  adv;         // single-column advances, applied before a tab
      logic        tab;         // tab completed
      logic        last;        // end of text, clear column afterwards
      logic        char_done;
      logic [20:0] code_point;
      logic        bad;
   } op_type;

   typedef struct packed {
      logic [7:0] tab_width;
      logic       clear_rem;    // tab width written this cycle
   } tab_cfg_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 full;
   } queue_status_type;

   function automatic logic is_wide(input logic [20:0] cp);
      return (cp >= 21'h01100 && cp <= 21'h0115F) ||
             (cp >= 21'h02329 && cp <= 21'h0232A) ||
             (cp >= 21'h02E80 && cp <= 21'h0A4CF && cp != 21'h0303F) ||
             (cp >= 21'h0AC00 && cp <= 21'h0D7A3) ||
             (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
             (cp >= 21'h0FE10 && cp <= 21'h0FE19) ||
             (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
             (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
             (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
             (cp >= 21'h1F300 && cp <= 21'h1F64F) ||
             (cp >= 21'h1F900 && cp <= 21'h1F9FF);
   endfunction

endpackage

// ===== sv/utf8dc_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 display column counter - decoder front end
// Tracks the open multi-byte sequence and turns each input word into an
// operation record: column advances, tab, completed code point, error flag.
// ----------------------------------------------------------------------------
module utf8dc_front
   import utf8dc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // text_byte[7:0]
   input  logic       req_tlast,    // end_of_text
   input  logic       q_full,
   output logic       push,
   output op_type     push_op
);

   logic [1:0]  expected_ff, expected_in;
   logic [1:0]  taken_ff,    taken_in;
   logic [20:0] partial_ff,  partial_in;

   logic [20:0] cont_value;
   logic [1:0]  cont_taken;
   logic        as_lead;
   logic [2:0]  adv;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   assign cont_value = {partial_ff[14:0], req_tdata[5:0] & PAYLOAD_MASK[5:0]};
   assign cont_taken = taken_ff + 2'd1;

   always_comb begin
      expected_in = expected_ff;
      taken_in    = taken_ff;
      partial_in  = partial_ff;
      as_lead     = 1'b1;
      adv         = 3'd0;
      push_op     = '0;

      // open sequence: continuation or broken sequence
      if (expected_ff != 2'd0) begin
         if ((req_tdata & CONT_MASK) == CONT_TAG) begin
            as_lead = 1'b0;
            if (cont_taken == expected_ff) begin
               push_op.char_done  = 1'b1;
               push_op.code_point = cont_value;
               expected_in        = 2'd0;
               taken_in           = 2'd0;
               partial_in         = '0;
            end else begin
               taken_in   = cont_taken;
               partial_in = cont_value;
            end
         end else begin
            adv         = 3'd1 + 3'(taken_ff);
            push_op.bad = 1'b1;
            expected_in = 2'd0;
            taken_in    = 2'd0;
            partial_in  = '0;
         end
      end

      if (as_lead) begin
         if (!req_tdata[7]) begin
            push_op.char_done  = 1'b1;
            push_op.code_point = {13'd0, req_tdata};
         end else if ((req_tdata & LEAD2_MASK) == LEAD2_TAG) begin
            expected_in = 2'd1;
            partial_in  = {16'd0, req_tdata[4:0]};
         end else if ((req_tdata & LEAD3_MASK) == LEAD3_TAG) begin
            expected_in = 2'd2;
            partial_in  = {17'd0, req_tdata[3:0]};
         end else if ((req_tdata & LEAD4_MASK) == LEAD4_TAG) begin
            expected_in = 2'd3;
            partial_in  = {18'd0, req_tdata[2:0]};
         end else begin
            adv         = adv + 3'd1;
            push_op.bad = 1'b1;
         end
      end

      if (push_op.char_done) begin
         if (push_op.code_point == CP_TAB) begin
            push_op.tab = 1'b1;
         end else begin
            adv = adv + (is_wide(push_op.code_point) ? 3'd2 : 3'd1);
         end
      end

      // end of text flushes pending bytes, one column each
      if (req_tlast) begin
         if (expected_in != 2'd0) begin
            adv         = adv + 3'd1 + 3'(taken_in);
            push_op.bad = 1'b1;
         end
         expected_in = 2'd0;
         taken_in    = 2'd0;
         partial_in  = '0;
      end

      push_op.adv  = adv;
      push_op.last = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 2'd0;
         taken_ff    <= 2'd0;
         partial_ff  <= '0;
      end else if (push) begin
         expected_ff <= expected_in;
         taken_ff    <= taken_in;
         partial_ff  <= partial_in;
      end
   end

endmodule

// ===== sv/utf8dc_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 display column counter - operation queue
// Short FIFO of operation records between decoder and column unit.
// ----------------------------------------------------------------------------
module utf8dc_queue
   import utf8dc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_op,
   input  logic             pop,
   output logic             head_valid,
   output op_type           head_op,
   output queue_status_type status
);

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff,  count_in;

   assign head_valid   = (count_ff != '0);
   assign head_op      = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/utf8dc_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 display column counter - column unit
// Applies one operation record per cycle, while the output is not stalled,
// to the running column and tab remainder, and holds the result word in the output register.
// ----------------------------------------------------------------------------
module utf8dc_back
   import utf8dc_pkg::*;
#(
   parameter int COLUMN_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  tab_cfg_type cfg,
   input  logic        head_valid,
   input  op_type      head_op,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // column[31:0], code_point[52:32], zero pad
   output logic [1:0]  rsp_tuser    // char_done[0], bad_bytes_seen[1]
);

   localparam int SUM_BITS = COLUMN_BITS + 2;
   localparam int EXT_BITS = COLUMN_BITS + 32;

   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [7:0]             rem_ff,    rem_in;
   logic                   rsp_valid_ff;
   logic [31:0]            out_column_ff;
   logic [20:0]            out_cp_ff;
   logic                   out_done_ff;
   logic                   out_bad_ff;

   logic [7:0]             tab_stop;
   logic [7:0]             rem_adv;
   logic [8:0]             delta;
   logic [SUM_BITS-1:0]    sum;
   logic [EXT_BITS-1:0]    column_ext;

   assign pop      = head_valid && (!rsp_valid_ff || rsp_tready);
   assign tab_stop = (cfg.tab_width == 8'd0) ? TAB_WIDTH_ZERO : cfg.tab_width;

   // single-column steps of the remainder, at most MAX_ADV of them
   always_comb begin
      rem_adv = rem_ff;
      for (int i = 0; i < MAX_ADV; i++) begin
         if (3'(i) < head_op.adv) begin
            rem_adv = (rem_adv + 8'd1 >= tab_stop) ? 8'd0 : rem_adv + 8'd1;
         end
      end
   end

   always_comb begin
      delta = 9'(head_op.adv) + (head_op.tab ? 9'(tab_stop - rem_adv) : 9'd0);
      sum   = SUM_BITS'(column_ff) + SUM_BITS'(delta);
      if (sum[SUM_BITS-1:COLUMN_BITS] != '0) begin
         column_in = '1;
      end else begin
         column_in = sum[COLUMN_BITS-1:0];
      end
      rem_in     = head_op.tab ? 8'd0 : rem_adv;
      column_ext = EXT_BITS'(column_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         rem_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            column_ff    <= head_op.last ? '0 : column_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.clear_rem) begin
            rem_ff <= 8'd0;
         end else if (pop) begin
            rem_ff <= head_op.last ? 8'd0 : rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_column_ff <= column_ext[31:0];
         out_cp_ff     <= head_op.code_point;
         out_done_ff   <= head_op.char_done;
         out_bad_ff    <= head_op.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, out_cp_ff, out_column_ff};
   assign rsp_tuser  = {out_bad_ff, out_done_ff};

endmodule

// ===== sv/utf8_display_column_counter.sv =====
// ----------------------------------------------------------------------------
// UTF-8 display column counter
// Streams UTF-8 text one byte per word and reports the display column after
// every byte, together with the completed code point and an error flag.
//
// Channels: req_* carries one text byte per word, req_tlast on the final byte
// of a text. rsp_* returns one word per byte: column and code point in
// tdata, char_done and bad_bytes_seen in tuser. csr_* is an APB-style port
// with one register, tab_width at byte address 0.
// Path: an accepted byte is written into the queue, then the column unit
// writes its result into the output register.
// Throughput: one byte per cycle while rsp_tready is high, set by the column
// unit, which applies one operation record per cycle unless the output stalls.
// Reset: sequence state, column, tab remainder, queue and output are cleared;
// tab_width returns to 8.
// Stall: when rsp_tready is low the output register holds its word; the
// two-entry queue absorbs further bytes and req_tready drops once it is full.
// ----------------------------------------------------------------------------
module utf8_display_column_counter
   import utf8dc_pkg::*;
#(
   parameter int COLUMN_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,

   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // text_byte[7:0]
   input  logic        req_tlast,     // end_of_text

   // result stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,     // column[31:0], code_point[52:32], zero pad
   output logic [1:0]  rsp_tuser,     // char_done[0], bad_bytes_seen[1]

   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             tab_width_ff;
   logic [7:0]       tab_reg_ff;
   logic             tab_write;
   tab_cfg_type      tab_cfg;

   logic             push;
   op_type           push_op;
   logic             pop;
   logic             head_valid;
   op_type           head_op;
   queue_status_type q_status;

   // ---- configuration port ----
   // Register select is paddr[2]; byte lanes within the word are ignored.
   assign csr_pready = 1'b1;
   assign tab_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_TAB_WIDTH);
   assign csr_prdata = (csr_paddr[2] == REG_TAB_WIDTH) ? {24'd0, tab_reg_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_reg_ff   <= TAB_WIDTH_RESET;
         tab_width_ff <= 1'b0;
      end else begin
         tab_width_ff <= tab_write;
         if (tab_write) begin
            tab_reg_ff <= csr_pwdata[7:0];
         end
      end
   end

   // A write restarts tab stops from the current column: the column unit
   // clears its remainder in the same cycle the register takes the value.
   assign tab_cfg.tab_width = tab_reg_ff;
   assign tab_cfg.clear_rem = tab_write;

   // ---- decoder: byte classification and sequence tracking ----
   utf8dc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_status.full),
      .push       (push),
      .push_op    (push_op)
   );

   // ---- operation queue ----
   utf8dc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op),
      .status     (q_status)
   );

   // ---- column unit and output register ----
   utf8dc_back #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (tab_cfg),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---- assertions ----
   // code point field is zero unless a character completed
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[52:32] == 21'd0)
      else $error("code point set without char_done");

   // an accepted byte is held in the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> q_status.count != '0)
      else $error("accepted byte lost before queue");

   // reset empties queue and output register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && q_status.count == '0)
      else $error("state left after reset");

   // the register write pulse is tracked in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      tab_write |=> tab_width_ff)
      else $error("tab width write not tracked");

endmodule
